// ===== rtl/crc8rx_pkg.sv =====
// crc8rx_pkg: shared types, constants and the CRC-8 byte step for the
// reply-frame receiver. No dependencies.
package crc8rx_pkg;

  localparam logic [7:0] FrameStart = 8'hAA;
  localparam int unsigned FrameLen = 11;
  localparam logic [7:0] CrcPoly = 8'h07;
  localparam logic [7:0] CrcInit = 8'h00;

  localparam logic [3:0] IdxHunt = 4'd0;
  localparam logic [3:0] IdxStatus = 4'd1;
  localparam logic [3:0] IdxPosLast = 4'd5;
  localparam logic [3:0] IdxCrc = 4'(FrameLen - 1);

  localparam logic FuncByte = 1'b0;
  localparam logic FuncTimeout = 1'b1;

  typedef enum logic [1:0] {
    OUT_GOOD    = 2'd0,
    OUT_BADCRC  = 2'd1,
    OUT_TIMEOUT = 2'd2
  } outcome_e;

  typedef struct packed {
    outcome_e           outcome;
    logic [7:0]         status_bits;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
  } result_t;

  // One byte through CRC-8, MSB first, no reflection, no final xor.
  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  localparam logic [7:0] CrcAfterStart = crc8_step(CrcInit, FrameStart);

endpackage

// ===== rtl/crc8rx_if.sv =====
// crc8rx_if: valid/ready channels of the reply-frame receiver, one for
// incoming byte/timeout items and one for frame results. Uses crc8rx_pkg.
interface crc8rx_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink (input valid, input func, input rx_byte, output ready);
endinterface

interface crc8rx_out_if
  import crc8rx_pkg::*;
;
  logic               valid;
  logic               ready;
  outcome_e           outcome;
  logic [7:0]         status_bits;
  logic signed [31:0] position;
  logic signed [31:0] velocity;

  modport source (output valid, output outcome, output status_bits,
                  output position, output velocity, input ready);
  modport sink (input valid, input outcome, input status_bits,
                input position, input velocity, output ready);
endinterface

// ===== rtl/crc8_response_frame_receiver.sv =====
// crc8_response_frame_receiver: deframer for 11-byte UART reply frames with
// CRC-8 check. Uses crc8rx_pkg and the channel interfaces in crc8rx_if.sv.
//
// Usage
//   in_i  : one item per received UART byte (func = 0, rx_byte) or per
//           expired reply timeout (func = 1).
//   out_o : one item per finished frame: good, CRC mismatch or timeout.
//           Status, position and velocity are only non-zero for a good frame.
//   Frame : 0xAA, status, position (LE, 4 bytes), velocity (LE, 4 bytes),
//           CRC-8 (poly 0x07, init 0) over the first ten bytes.
//           0xAA restarts the frame anywhere; other bytes are dropped while
//           hunting for a start byte.
// Timing
//   One item accepted every cycle while in_i.ready is high. The byte-wide
//   CRC step and the field shift feed the state registers; each result is
//   formed from the state registers and the accepted item and registered in
//   the result register, or in the skid entry while out_o is stalled.
// Stalls
//   A result register plus one skid entry: while out_o is stalled the
//   receiver keeps taking items until a second result is waiting, then
//   drops in_i.ready until the skid entry drains.
// Reset
//   rst_ni (async, active low) empties both result slots and puts the
//   receiver into start-byte hunting with the CRC cleared.
module crc8_response_frame_receiver
  import crc8rx_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  crc8rx_in_if.sink    in_i,
  crc8rx_out_if.source out_o
);

  // frame state
  logic [3:0]  byte_index_q, byte_index_d;
  logic [7:0]  running_crc_q, running_crc_d;
  logic [7:0]  status_hold_q, status_hold_d;
  logic [31:0] position_shift_q, position_shift_d;
  logic [31:0] velocity_shift_q, velocity_shift_d;

  // result register and skid entry
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;

  logic    in_acc;
  logic    res_valid;
  result_t res;
  logic    out_free;

  assign in_i.ready = !skid_valid_q;
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // Frame parser: next state and optional result for the item on in_i.
  always_comb begin
    byte_index_d     = byte_index_q;
    running_crc_d    = running_crc_q;
    status_hold_d    = status_hold_q;
    position_shift_d = position_shift_q;
    velocity_shift_d = velocity_shift_q;
    res_valid        = 1'b0;
    res              = '{outcome: OUT_TIMEOUT, status_bits: '0,
                         position: '0, velocity: '0};
    if (in_acc) begin
      priority if (in_i.func == FuncTimeout) begin
        byte_index_d  = IdxHunt;
        running_crc_d = CrcInit;
        res_valid     = 1'b1;
      end else if (in_i.rx_byte == FrameStart) begin
        // start byte wins at every position, CRC position included
        byte_index_d  = IdxStatus;
        running_crc_d = CrcAfterStart;
      end else if (byte_index_q == IdxHunt || byte_index_q > IdxCrc) begin
        byte_index_d = IdxHunt;
      end else if (byte_index_q == IdxCrc) begin
        byte_index_d  = IdxHunt;
        running_crc_d = CrcInit;
        res_valid     = 1'b1;
        if (in_i.rx_byte == running_crc_q) begin
          res.outcome     = OUT_GOOD;
          res.status_bits = status_hold_q;
          res.position    = position_shift_q;
          res.velocity    = velocity_shift_q;
        end else begin
          res.outcome = OUT_BADCRC;
        end
      end else begin
        if (byte_index_q == IdxStatus) begin
          status_hold_d = in_i.rx_byte;
        end else if (byte_index_q <= IdxPosLast) begin
          position_shift_d = {in_i.rx_byte, position_shift_q[31:8]};
        end else begin
          velocity_shift_d = {in_i.rx_byte, velocity_shift_q[31:8]};
        end
        running_crc_d = crc8_step(running_crc_q, in_i.rx_byte);
        byte_index_d  = byte_index_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q     <= IdxHunt;
      running_crc_q    <= CrcInit;
      status_hold_q    <= '0;
      position_shift_q <= '0;
      velocity_shift_q <= '0;
    end else begin
      byte_index_q     <= byte_index_d;
      running_crc_q    <= running_crc_d;
      status_hold_q    <= status_hold_d;
      position_shift_q <= position_shift_d;
      velocity_shift_q <= velocity_shift_d;
    end
  end

  // Result register with skid entry; skid only fills while out_o stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.outcome     = out_q.outcome;
  assign out_o.status_bits = out_q.status_bits;
  assign out_o.position    = out_q.position;
  assign out_o.velocity    = out_q.velocity;

  // assertions
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held with empty result register");

  a_skid_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !out_o.ready))
    else $error("skid entry filled without a stalled result");

  a_timeout_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.func == FuncTimeout) |=> out_valid_q && byte_index_q == IdxHunt)
    else $error("timeout item gave no result or left a frame open");

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_index_q <= IdxCrc)
    else $error("frame byte index beyond CRC position");

  a_good_needs_crc_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.outcome != OUT_TIMEOUT) |-> byte_index_q == IdxCrc)
    else $error("frame result outside the CRC position");

endmodule

// ===== sim/tb.sv =====
// tb: self-checking bench for crc8_response_frame_receiver, driving byte and timeout items
// and checking each frame report against a predictor kept inside the bench.
// Depends on crc8rx_pkg, the channel interfaces in crc8rx_if.sv and the receiver RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import crc8rx_pkg::*;

  localparam int unsigned CycleLimit = 400_000;

  logic clk_i;
  logic rst_ni;

  crc8rx_in_if  in_ch ();
  crc8rx_out_if out_ch ();

  crc8_response_frame_receiver i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the deframer.
  // rx_pos 0 = hunting, 1..10 = index of the next frame byte expected.
  // ---------------------------------------------------------------------------
  logic [3:0]  rx_pos      = IdxHunt;
  logic [7:0]  rx_crc      = CrcInit;
  logic [7:0]  rx_status   = '0;
  logic [31:0] rx_position = '0;
  logic [31:0] rx_velocity = '0;

  result_t     frame_reports_q[$];   // reports still owed by the receiver, oldest first

  int unsigned items_taken     = 0;  // items that did something (noise while hunting excluded)
  int unsigned mismatches      = 0;
  int unsigned cycle_count     = 0;
  int unsigned hold_off_cycles = 0;  // long receiver stall, counted down by the sink process
  bit          traffic_gaps    = 1'b1;

  // Clock: 8 ns period
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // CRC-8, poly 0x07, worked bit-serially MSB first; same result as a byte step.
  function automatic logic [7:0] crc8_fold(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    c = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ data[i];
      c  = {c[6:0], 1'b0};
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  // Advance the predictor by one accepted item and queue any report it owes.
  // Returns 0 only for a byte dropped while hunting.
  function automatic bit deframe_item(input logic fn, input logic [7:0] data);
    result_t rep;
    bit      used;
    rep  = '0;
    used = 1'b1;
    if (fn == FuncTimeout) begin
      // timeout always reports, frame in progress or not
      rx_pos      = IdxHunt;
      rx_crc      = CrcInit;
      rep.outcome = OUT_TIMEOUT;
      frame_reports_q.push_back(rep);
    end else if (data == FrameStart) begin
      // start byte restarts the frame wherever we are, CRC slot included
      rx_crc = crc8_fold(CrcInit, data);
      rx_pos = IdxStatus;
    end else if (rx_pos == IdxHunt || rx_pos > IdxCrc) begin
      rx_pos = IdxHunt;
      used   = 1'b0;
    end else if (rx_pos == IdxCrc) begin
      rx_pos = IdxHunt;
      if (data == rx_crc) begin
        rep.outcome     = OUT_GOOD;
        rep.status_bits = rx_status;
        rep.position    = rx_position;
        rep.velocity    = rx_velocity;
      end else begin
        rep.outcome = OUT_BADCRC;
      end
      rx_crc = CrcInit;
      frame_reports_q.push_back(rep);
    end else begin
      if (rx_pos == IdxStatus) begin
        rx_status = data;
      end else if (rx_pos <= IdxPosLast) begin
        rx_position = {data, rx_position[31:8]};   // little endian: later bytes go high
      end else begin
        rx_velocity = {data, rx_velocity[31:8]};
      end
      rx_crc = crc8_fold(rx_crc, data);
      rx_pos = rx_pos + 4'd1;
    end
    return used;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one item per call, optional idle burst first. Inputs change on the
  // falling edge; acceptance is seen on the rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic fn, input logic [7:0] data);
    int unsigned gap;
    if (traffic_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_ch.valid   <= 1'b1;
    in_ch.func    <= fn;
    in_ch.rx_byte <= data;
    do @(posedge clk_i); while (!in_ch.ready);
    if (deframe_item(fn, data)) begin
      items_taken++;
    end
  endtask

  // Fill an 11-byte frame; a bad CRC byte never equals the true CRC or the start byte.
  function automatic void build_frame(output logic [7:0] fr [11], input logic [7:0] st,
                                      input logic [31:0] pos, input logic [31:0] vel,
                                      input bit crc_ok);
    logic [7:0] crc;
    fr[0] = FrameStart;
    fr[1] = st;
    for (int k = 0; k < 4; k++) begin
      fr[2 + k] = pos[8 * k +: 8];
      fr[6 + k] = vel[8 * k +: 8];
    end
    crc = CrcInit;
    for (int k = 0; k < 10; k++) begin
      crc = crc8_fold(crc, fr[k]);
    end
    if (crc_ok) begin
      fr[10] = crc;
    end else begin
      do fr[10] = 8'($urandom); while (fr[10] == crc || fr[10] == FrameStart);
    end
  endfunction

  task automatic send_bytes(input logic [7:0] fr [11], input int unsigned first,
                            input int unsigned last);
    for (int unsigned k = first; k <= last; k++) begin
      send_item(FuncByte, fr[k]);
    end
  endtask

  // Mostly random words, with the signed extremes and all-zero/all-one mixed in.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sink: random stalls in bursts, plus a long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall_left;
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles != 0) begin
        hold_off_cycles--;
        out_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (traffic_gaps && $urandom_range(0, 7) == 0) begin
        stall_left   = $urandom_range(1, 15) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every accepted report against the oldest one owed.
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (frame_reports_q.size() == 0) begin
        mismatches++;
        $display("%0t: report with none owed, expected nothing, actual outcome %0d",
                 $time, out_ch.outcome);
      end else begin
        want = frame_reports_q.pop_front();
        if (out_ch.outcome !== want.outcome) begin
          note_mismatch("outcome", 32'(want.outcome), 32'(out_ch.outcome));
        end
        if (out_ch.status_bits !== want.status_bits) begin
          note_mismatch("status_bits", 32'(want.status_bits), 32'(out_ch.status_bits));
        end
        if (out_ch.position !== want.position) begin
          note_mismatch("position", want.position, out_ch.position);
        end
        if (out_ch.velocity !== want.velocity) begin
          note_mismatch("velocity", want.velocity, out_ch.velocity);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("crc8_response_frame_receiver regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Timeout while hunting, a dropped byte, then a timeout cutting a frame short.
  task automatic test_timeout_paths();
    send_item(FuncTimeout, 8'hFF);
    send_item(FuncByte, 8'h00);
    send_item(FuncByte, FrameStart);
    send_item(FuncByte, 8'h5A);
    send_item(FuncTimeout, 8'h00);
  endtask

  // Good frame: status zero, position most negative, velocity most positive.
  task automatic test_good_frame_extremes();
    logic [7:0] fr [11];
    build_frame(fr, 8'h00, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    send_bytes(fr, 0, 10);
  endtask

  // Start byte in a data slot restarts; the restarted frame then fails its CRC.
  task automatic test_restart_bad_crc();
    logic [7:0] fr [11];
    send_item(FuncByte, FrameStart);
    send_item(FuncByte, 8'h3C);
    build_frame(fr, 8'hFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_bytes(fr, 0, 10);
  endtask

  // Sink holds off for a long stretch while the sender keeps offering timeouts
  // and frames, so both result slots fill and in_i.ready drops.
  task automatic test_backpressure();
    logic [7:0] fr [11];
    traffic_gaps    = 1'b0;
    hold_off_cycles = 300;
    for (int k = 0; k < 30; k++) begin
      if (k % 10 == 0) begin
        build_frame(fr, 8'($urandom), pick_word(), pick_word(), 1'b1);
        send_bytes(fr, 0, 10);
      end
      send_item(FuncTimeout, 8'($urandom));
    end
    traffic_gaps = 1'b1;
  endtask

  // Mostly well-formed frames with random content; the rest bad CRCs, frames cut
  // by a timeout, frames restarted at any slot, noise and lone timeouts.
  task automatic test_random_traffic(input int unsigned n_items);
    logic [7:0]  fr [11];
    int unsigned target;
    int unsigned pick;
    int unsigned cut;
    target = items_taken + n_items;
    while (items_taken < target) begin
      pick = $urandom_range(0, 99);
      build_frame(fr, 8'($urandom), pick_word(), pick_word(), pick >= 60 && pick < 70 ? 1'b0 : 1'b1);
      if (pick < 70) begin
        send_bytes(fr, 0, 10);
      end else if (pick < 78) begin
        cut = $urandom_range(0, 9);
        send_bytes(fr, 0, cut);
        send_item(FuncTimeout, 8'($urandom));
      end else if (pick < 86) begin
        // cut short, then a fresh frame whose start byte lands in slot cut+1
        cut = $urandom_range(0, 9);
        send_bytes(fr, 0, cut);
        build_frame(fr, 8'($urandom), pick_word(), pick_word(), 1'b1);
        send_bytes(fr, 0, 10);
      end else if (pick < 93) begin
        repeat ($urandom_range(1, 4)) send_item(FuncByte, 8'($urandom));
      end else begin
        send_item(FuncTimeout, 8'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.func    = FuncByte;
    in_ch.rx_byte = 8'h00;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    test_timeout_paths();
    test_good_frame_extremes();
    test_restart_bad_crc();
    test_backpressure();
    test_random_traffic(1100);
    traffic_gaps = 1'b0;   // closing stretch runs flat out on both sides
    test_random_traffic(300);

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (frame_reports_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);   // catch any stray report
    @(negedge clk_i);
    if (mismatches == 0) begin
      $display("crc8_response_frame_receiver regression: pass");
    end else begin
      $display("crc8_response_frame_receiver regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/crc8rx_pkg.sv
rtl/crc8rx_if.sv
rtl/crc8_response_frame_receiver.sv
sim/tb.sv
